>>> src/hit_bitmap_report_compactor_macros.svh
`ifndef HIT_BITMAP_REPORT_COMPACTOR_MACROS_SVH
`define HIT_BITMAP_REPORT_COMPACTOR_MACROS_SVH

// Check a property while out of reset.
`define HBRC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbrc assertion failed");

// Check a property at every edge, reset included.
`define HBRC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hbrc assertion failed");

`endif

>>> src/hbrc_pkg.sv
package hbrc_pkg;

  localparam int SLICE_BITS_DEF  = 48;
  localparam int SLICE_COUNT_DEF = 256;

  localparam int HITS_W     = 48;
  localparam int SLICE_W    = 8;
  localparam int INDEX_W    = 14;
  localparam int SEG_W      = 26;
  localparam int POS_W      = 24;
  localparam int REPORT_W   = INDEX_W + SEG_W + POS_W;
  localparam int COUNT_W    = 32;
  localparam int BIT_W      = $clog2(HITS_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic [SEG_W-1:0]   segment_index;
    logic [POS_W-1:0]   model_position;
    logic [SLICE_W-1:0] slice_number;
    logic [HITS_W-1:0]  slice_hits;
    logic               end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [REPORT_W-1:0] packed_report;
    logic [COUNT_W-1:0]  slot_or_count;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [HITS_W-1:0]  hits;
    logic [INDEX_W-1:0] base_cell;
    logic [SEG_W-1:0]   segment;
    logic [POS_W-1:0]   position;
    logic               eob;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

>>> src/hbrc_queue.sv
module hbrc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  hbrc_pkg::q_push_t push,
  input  logic             pop,
  output logic             full,
  output hbrc_pkg::q_head_t head
);

  localparam int DEPTH = hbrc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hbrc_pkg::q_entry_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = entry_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

>>> src/hbrc_front.sv
module hbrc_front #(
  parameter int SLICE_BITS  = hbrc_pkg::SLICE_BITS_DEF,
  parameter int SLICE_COUNT = hbrc_pkg::SLICE_COUNT_DEF
) (
  input  logic               in_valid,
  input  hbrc_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               in_stall,
  output hbrc_pkg::q_push_t  push
);

  localparam int HW = hbrc_pkg::HITS_W;
  localparam int IW = hbrc_pkg::INDEX_W;
  localparam logic [HW-1:0] SLICE_MASK = {HW{1'b1}} >> (HW - SLICE_BITS);

  logic          slice_ok;
  logic [HW-1:0] hits_m;
  logic [IW-1:0] base_cell;

  assign slice_ok  = ({1'b0, in_item.slice_number} < 9'(SLICE_COUNT));
  assign hits_m    = slice_ok ? (in_item.slice_hits & SLICE_MASK) : '0;
  assign base_cell = IW'(IW'(in_item.slice_number) * IW'(SLICE_BITS));

  assign in_stall = q_full;

  // drop slices that produce no result
  assign push.valid          = in_valid && !q_full && ((|hits_m) || in_item.end_of_batch);
  assign push.entry.hits      = hits_m;
  assign push.entry.base_cell = base_cell;
  assign push.entry.segment   = in_item.segment_index;
  assign push.entry.position  = in_item.model_position;
  assign push.entry.eob       = in_item.end_of_batch;

endmodule

>>> src/hbrc_back.sv
module hbrc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hbrc_pkg::q_head_t   q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hbrc_pkg::out_item_t out_item
);

  localparam int HW = hbrc_pkg::HITS_W;
  localparam int BW = hbrc_pkg::BIT_W;
  localparam int IW = hbrc_pkg::INDEX_W;
  localparam int CW = hbrc_pkg::COUNT_W;

  logic                busy_r, busy_nxt;
  hbrc_pkg::q_entry_t  cur_r, cur_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  hbrc_pkg::out_item_t out_r, out_nxt;

  logic          adv;
  logic [HW-1:0] hits_rest;
  logic [BW-1:0] bit_idx;
  logic [IW-1:0] cell_idx;

  assign adv       = !out_valid_r || !out_stall;
  assign hits_rest = cur_r.hits & (cur_r.hits - HW'(1));
  assign cell_idx  = cur_r.base_cell + IW'(bit_idx);
  assign pop       = !busy_r && q_head.valid;

  always_comb begin
    bit_idx = '0;
    for (int b = HW - 1; b >= 0; b--) begin
      if (cur_r.hits[b]) begin
        bit_idx = BW'(b);
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (pop) begin
      busy_nxt = 1'b1;
      cur_nxt  = q_head.entry;
    end else if (busy_r && adv) begin
      out_valid_nxt = 1'b1;
      if (|cur_r.hits) begin
        out_nxt.result_kind   = hbrc_pkg::KIND_HIT;
        out_nxt.packed_report = {cur_r.position, cur_r.segment, cell_idx};
        out_nxt.slot_or_count = count_r;
        out_nxt.last_of_run   = (hits_rest == '0) && !cur_r.eob;
        cur_nxt.hits          = hits_rest;
        if (count_r != hbrc_pkg::COUNT_MAX) begin
          count_nxt = count_r + CW'(1);
        end
        if ((hits_rest == '0) && !cur_r.eob) begin
          busy_nxt = 1'b0;
        end
      end else begin
        out_nxt.result_kind   = hbrc_pkg::KIND_COUNT;
        out_nxt.packed_report = '0;
        out_nxt.slot_or_count = count_r;
        out_nxt.last_of_run   = 1'b1;
        count_nxt             = '0;
        busy_nxt              = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> src/hit_bitmap_report_compactor.sv
// A slice's first result passes through the queue, cur_r and the output register.
// Slices that yield nothing are dropped at the input, one per cycle unless the queue is full;
//   others give one result per set bit, plus one more when end_of_batch is set,
//   one result per cycle from the bit-scan unit while out_stall is low; a 2-entry queue decouples input.
// Reset: synchronous, active low; clears the queue, report counter and output valid.
module hit_bitmap_report_compactor #(
  parameter int SLICE_BITS  = hbrc_pkg::SLICE_BITS_DEF,
  parameter int SLICE_COUNT = hbrc_pkg::SLICE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hbrc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hbrc_pkg::out_item_t out_item
);

  hbrc_pkg::q_push_t push;
  hbrc_pkg::q_head_t q_head;
  logic              q_full;
  logic              pop;

  hbrc_front #(
    .SLICE_BITS  (SLICE_BITS),
    .SLICE_COUNT (SLICE_COUNT)
  ) u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push)
  );

  hbrc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (q_head)
  );

  hbrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> src/hbrc_checker.sv
`include "hit_bitmap_report_compactor_macros.svh"

module hbrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hbrc_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input hbrc_pkg::out_item_t out_item
);

  `HBRC_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_item))
  `HBRC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item))
  `HBRC_ASSERT(a_count_last, clk, rst_n, out_valid && (out_item.result_kind == hbrc_pkg::KIND_COUNT) |-> out_item.last_of_run)
  `HBRC_ASSERT(a_count_zero, clk, rst_n, out_valid && (out_item.result_kind == hbrc_pkg::KIND_COUNT) |-> (out_item.packed_report == '0))
  `HBRC_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid)

endmodule

bind hit_bitmap_report_compactor hbrc_checker u_hbrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
